@@ hdl/bb3_pkg.sv @@
// shared types, constants and a helper function of the 3x3 box blur core
package bb3_pkg;

    // image geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // widths of the configuration registers
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;

    // counter widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
    localparam int EROW_W = $clog2(MAX_HEIGHT);

    // register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1);

    // configuration address map
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // request types
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // window queue and result queue sizes
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int ODEPTH = 4;
    localparam int OPTR_W = $clog2(ODEPTH);
    localparam int OCNT_W = $clog2(ODEPTH + 1);

    // arithmetic widths of the mean
    localparam int SUM_W   = 12;
    localparam int NUM_W   = 13;
    localparam int RECIP_W = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W  = NUM_W + RECIP_W;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // one finished window with its border flags
    typedef struct packed {
        t_pixel [8:0] win;
        logic         up_ok;
        logic         dn_ok;
        logic         lf_ok;
        logic         rt_ok;
        logic         last;
    } t_win_entry;

    // geometry and restart request towards the front
    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
        logic                restart;
    } t_cfg;

    // reciprocal of 2*count scaled by 2^RECIP_SHIFT, rounded up
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = RECIP_W'(32768);
            4'd2:    m = RECIP_W'(16384);
            4'd3:    m = RECIP_W'(10923);
            4'd4:    m = RECIP_W'(8192);
            4'd6:    m = RECIP_W'(5462);
            4'd9:    m = RECIP_W'(3641);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/bb3_front.sv @@
// front part: raster counters, line stores, window and result classification
module bb3_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bb3_pkg::t_cfg             i_cfg,
    input  logic                      i_push,
    input  logic                      i_req_type,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    input  logic [bb3_pkg::QCNT_W-1:0] i_q_count,
    output logic                      o_full,
    output logic                      o_q_push,
    output bb3_pkg::t_win_entry       o_q_entry
);

    logic [bb3_pkg::COL_W-1:0]  r_col,  n_col;
    logic [bb3_pkg::ROW_W-1:0]  r_row,  n_row;
    logic [bb3_pkg::COL_W-1:0]  r_ecol, n_ecol;
    logic [bb3_pkg::EROW_W-1:0] r_erow, n_erow;

    logic r_b_valid;
    logic r_b_emit;
    logic r_b_fwd;
    logic r_b_up_ok, r_b_dn_ok, r_b_lf_ok, r_b_rt_ok, r_b_last;
    logic [bb3_pkg::COL_W-1:0] r_b_col;
    bb3_pkg::t_pixel r_b_pix;

    logic [47:0] r_mem [bb3_pkg::MAX_WIDTH];
    logic [47:0] r_rd;
    bb3_pkg::t_pixel r_wr_mid, r_wr_pix;
    bb3_pkg::t_pixel r_win [9];
    bb3_pkg::t_pixel n_win [9];
    bb3_pkg::t_pixel b_up, b_mid;

    logic accept;
    logic emit, fin;
    logic up_ok, dn_ok, lf_ok, rt_ok;
    logic [bb3_pkg::WIDTH_W-1:0]  w_last;
    logic [bb3_pkg::HEIGHT_W-1:0] h_last;
    logic [bb3_pkg::QCNT_W-1:0]   pending;

    // room check: queue entries plus a window about to be pushed
    assign pending = i_q_count + bb3_pkg::QCNT_W'(r_b_valid && r_b_emit);
    assign o_full  = pending >= bb3_pkg::QCNT_W'(bb3_pkg::QDEPTH);
    assign accept  = i_push && !o_full;

    // classification of the item being accepted
    assign w_last = i_cfg.width - bb3_pkg::WIDTH_W'(1);
    assign h_last = i_cfg.height - bb3_pkg::HEIGHT_W'(1);
    assign emit   = (r_row > bb3_pkg::ROW_W'(1)) ||
                    ((r_row == bb3_pkg::ROW_W'(1)) && (r_col != '0));
    assign up_ok  = r_erow != '0;
    assign dn_ok  = bb3_pkg::HEIGHT_W'(r_erow) != h_last;
    assign lf_ok  = r_ecol != '0;
    assign rt_ok  = bb3_pkg::WIDTH_W'(r_ecol) != w_last;
    assign fin    = emit && !dn_ok && !rt_ok;

    // raster and result position counters
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_ecol = r_ecol;
        n_erow = r_erow;
        if (i_cfg.restart) begin
            n_col  = '0;
            n_row  = '0;
            n_ecol = '0;
            n_erow = '0;
        end else if (accept) begin
            if (fin) begin
                n_col  = '0;
                n_row  = '0;
                n_ecol = '0;
                n_erow = '0;
            end else begin
                if (emit) begin
                    if (!rt_ok) begin
                        n_ecol = '0;
                        n_erow = r_erow + bb3_pkg::EROW_W'(1);
                    end else begin
                        n_ecol = r_ecol + bb3_pkg::COL_W'(1);
                    end
                end
                if (bb3_pkg::WIDTH_W'(r_col) == w_last) begin
                    n_col = '0;
                    n_row = r_row + bb3_pkg::ROW_W'(1);
                end else begin
                    n_col = r_col + bb3_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_ecol    <= '0;
            r_erow    <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_ecol    <= n_ecol;
            r_erow    <= n_erow;
            r_b_valid <= accept;
        end
    end

    // item register for the store and window stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_col   <= r_col;
            r_b_emit  <= emit;
            r_b_fwd   <= r_b_valid && (r_b_col == r_col);
            r_b_up_ok <= up_ok;
            r_b_dn_ok <= dn_ok;
            r_b_lf_ok <= lf_ok;
            r_b_rt_ok <= rt_ok;
            r_b_last  <= fin;
            if (i_req_type == bb3_pkg::REQ_PIXEL) begin
                r_b_pix <= '{red: i_red, green: i_green, blue: i_blue};
            end else begin
                r_b_pix <= '0;
            end
        end
    end

    // line stores: upper row in the high half, lower row in the low half
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_col];
        if (r_b_valid) begin
            r_mem[r_b_col] <= {b_mid, r_b_pix};
        end
    end

    // bypass for an item at the column that the item ahead of it is still writing
    assign b_up  = r_b_fwd ? r_wr_mid : r_rd[47:24];
    assign b_mid = r_b_fwd ? r_wr_pix : r_rd[23:0];

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_wr_mid <= b_mid;
            r_wr_pix <= r_b_pix;
        end
    end

    // window shift: right column takes the two stored rows and the new pixel
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_win[r*3]     = r_win[r*3 + 1];
            n_win[r*3 + 1] = r_win[r*3 + 2];
        end
        n_win[2] = b_up;
        n_win[5] = b_mid;
        n_win[8] = r_b_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // window entry towards the back
    assign o_q_push = r_b_valid && r_b_emit;
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_q_entry.win[k] = n_win[k];
        end
        o_q_entry.up_ok = r_b_up_ok;
        o_q_entry.dn_ok = r_b_dn_ok;
        o_q_entry.lf_ok = r_b_lf_ok;
        o_q_entry.rt_ok = r_b_rt_ok;
        o_q_entry.last  = r_b_last;
    end

endmodule

@@ hdl/bb3_queue.sv @@
// short queue of finished windows between front and back
module bb3_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  bb3_pkg::t_win_entry        i_entry,
    input  logic                       i_pop,
    output bb3_pkg::t_win_entry        o_entry,
    output logic                       o_empty,
    output logic [bb3_pkg::QCNT_W-1:0] o_count
);

    bb3_pkg::t_win_entry r_data [bb3_pkg::QDEPTH];
    logic [bb3_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [bb3_pkg::QCNT_W-1:0] r_count;
    logic do_pop;

    assign o_empty = r_count == '0;
    assign o_count = r_count;
    assign o_entry = r_data[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + bb3_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + bb3_pkg::QPTR_W'(1);
            end
            r_count <= r_count + bb3_pkg::QCNT_W'(i_push) - bb3_pkg::QCNT_W'(do_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_entry;
        end
    end

endmodule

@@ hdl/bb3_back.sv @@
// back part: masked window sums, rounded mean by reciprocal, result queue
module bb3_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bb3_pkg::t_win_entry i_q_entry,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic                o_last
);

    logic [8:0] ok;
    logic [2:0] row_ok, col_ok;
    logic [1:0] nr, nc;
    logic [3:0] cnt;
    logic [bb3_pkg::SUM_W-1:0] sum [3];
    logic [bb3_pkg::NUM_W-1:0] num [3];

    logic r_c_valid, r_d_valid;
    logic r_c_last, r_d_last;
    logic [bb3_pkg::NUM_W-1:0]   r_c_num [3];
    logic [bb3_pkg::RECIP_W-1:0] r_c_recip;
    logic [bb3_pkg::PROD_W-1:0]  r_d_prod [3];

    logic [24:0] r_out [bb3_pkg::ODEPTH];
    logic [bb3_pkg::OPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [bb3_pkg::OCNT_W-1:0] r_count;
    logic [bb3_pkg::OCNT_W-1:0] inflight;
    logic [24:0] head;
    logic do_pop;

    // issue only when the result queue has room for all windows in flight
    assign inflight = r_count + bb3_pkg::OCNT_W'(r_c_valid) + bb3_pkg::OCNT_W'(r_d_valid);
    assign o_q_pop  = !i_q_empty && (inflight < bb3_pkg::OCNT_W'(bb3_pkg::ODEPTH));

    // neighbors inside the image and their count
    assign row_ok = {i_q_entry.dn_ok, 1'b1, i_q_entry.up_ok};
    assign col_ok = {i_q_entry.rt_ok, 1'b1, i_q_entry.lf_ok};
    assign nr  = 2'd1 + 2'(i_q_entry.up_ok) + 2'(i_q_entry.dn_ok);
    assign nc  = 2'd1 + 2'(i_q_entry.lf_ok) + 2'(i_q_entry.rt_ok);
    assign cnt = 4'(nr) * 4'(nc);

    // per channel masked sum, then 2*sum + count
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                ok[r*3 + c] = row_ok[r] && col_ok[c];
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = '0;
        end
        for (int k = 0; k < 9; k++) begin
            if (ok[k]) begin
                sum[0] = sum[0] + bb3_pkg::SUM_W'(i_q_entry.win[k].red);
                sum[1] = sum[1] + bb3_pkg::SUM_W'(i_q_entry.win[k].green);
                sum[2] = sum[2] + bb3_pkg::SUM_W'(i_q_entry.win[k].blue);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            num[ch] = {sum[ch], 1'b0} + bb3_pkg::NUM_W'(cnt);
        end
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_c_valid <= o_q_pop;
            r_d_valid <= r_c_valid;
        end
    end

    // sum stage and multiply stage
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_c_num[ch] <= num[ch];
            end
            r_c_recip <= bb3_pkg::recip(cnt);
            r_c_last  <= i_q_entry.last;
        end
        if (r_c_valid) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_d_prod[ch] <= bb3_pkg::PROD_W'(r_c_num[ch]) *
                                bb3_pkg::PROD_W'(r_c_recip);
            end
            r_d_last <= r_c_last;
        end
    end

    // result queue
    assign do_pop  = i_pop && !o_empty;
    assign o_empty = r_count == '0;
    assign head    = r_out[r_rd_ptr];
    assign o_red   = head[24:17];
    assign o_green = head[16:9];
    assign o_blue  = head[8:1];
    assign o_last  = head[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (r_d_valid) begin
                r_wr_ptr <= r_wr_ptr + bb3_pkg::OPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + bb3_pkg::OPTR_W'(1);
            end
            r_count <= r_count + bb3_pkg::OCNT_W'(r_d_valid) - bb3_pkg::OCNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d_valid) begin
            r_out[r_wr_ptr] <= {r_d_prod[0][bb3_pkg::RECIP_SHIFT +: 8],
                                r_d_prod[1][bb3_pkg::RECIP_SHIFT +: 8],
                                r_d_prod[2][bb3_pkg::RECIP_SHIFT +: 8],
                                r_d_last};
        end
    end

endmodule

@@ hdl/box_blur_3x3_stream_core.sv @@
// top level of the 3x3 box blur stream core with its configuration registers
//
// Pixels enter in raster order, one request per clock unless full, and each
// leaves as the rounded mean of its 3x3 neighbors inside the image. A pixel's
// result is ready once width+1 further requests have arrived; after the last
// pixel send width+1 drain requests to flush the frame, and the final result
// carries last_pixel. The sustained rate, while not full, is one request per
// cycle, set by the single line store RAM that each request reads and then
// writes at its column. Each result passes the window queue, the sum and
// multiply stages and the result queue. Both line stores live in one
// 1024 x 48 RAM that needs no clearing after reset. Writing either register
// restarts the frame.
module box_blur_3x3_stream_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bb3_pkg::ADDR_W-1:0]  paddr,
    input  logic [bb3_pkg::DATA_W-1:0]  pwdata,
    output logic [bb3_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // request side
    input  logic                        push,
    output logic                        full,
    input  logic                        i_req_type,
    input  logic [7:0]                  i_in_red,
    input  logic [7:0]                  i_in_green,
    input  logic [7:0]                  i_in_blue,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  o_out_red,
    output logic [7:0]                  o_out_green,
    output logic [7:0]                  o_out_blue,
    output logic                        o_last_pixel
);

    logic [bb3_pkg::WIDTH_W-1:0]  r_width;
    logic [bb3_pkg::HEIGHT_W-1:0] r_height;
    logic cfg_wr;
    bb3_pkg::t_cfg cfg;

    logic                        q_push, q_pop, q_empty;
    bb3_pkg::t_win_entry         q_in, q_out;
    logic [bb3_pkg::QCNT_W-1:0]  q_count;

    // register writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bb3_pkg::WIDTH_RESET;
            r_height <= bb3_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                bb3_pkg::REG_WIDTH:  r_width  <= pwdata[bb3_pkg::WIDTH_W-1:0];
                bb3_pkg::REG_HEIGHT: r_height <= pwdata[bb3_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (paddr[2])
            bb3_pkg::REG_HEIGHT: prdata = bb3_pkg::DATA_W'(r_height);
            default:             prdata = bb3_pkg::DATA_W'(r_width);
        endcase
    end

    // effective geometry, clamped to the supported range
    always_comb begin
        if (r_width == '0) begin
            cfg.width = bb3_pkg::WIDTH_W'(1);
        end else if (r_width > bb3_pkg::WIDTH_W'(bb3_pkg::MAX_WIDTH)) begin
            cfg.width = bb3_pkg::WIDTH_W'(bb3_pkg::MAX_WIDTH);
        end else begin
            cfg.width = r_width;
        end
        if (r_height == '0) begin
            cfg.height = bb3_pkg::HEIGHT_W'(1);
        end else if (r_height > bb3_pkg::HEIGHT_W'(bb3_pkg::MAX_HEIGHT)) begin
            cfg.height = bb3_pkg::HEIGHT_W'(bb3_pkg::MAX_HEIGHT);
        end else begin
            cfg.height = r_height;
        end
        cfg.restart = cfg_wr;
    end

    bb3_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_red      (i_in_red),
        .i_green    (i_in_green),
        .i_blue     (i_in_blue),
        .i_q_count  (q_count),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_q_entry  (q_in)
    );

    bb3_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    bb3_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_entry (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_red     (o_out_red),
        .o_green   (o_out_green),
        .o_blue    (o_out_blue),
        .o_last    (o_last_pixel)
    );

endmodule

@@ tb/tb.sv @@
// self-checking testbench of the 3x3 box blur stream core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_GIVEN
    } t_chk;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_out;

    typedef struct packed {
        logic            req;
        bb3_pkg::t_pixel px;
        t_chk            chk;
        t_blur_out       want;
    } t_dir_row;

    localparam int              HOLD_AT     = 200;
    localparam int              HOLD_LEN    = 600;
    localparam int              TAIL_CYC    = 20;
    localparam int              RAND_ITEMS  = 700;
    localparam int              PRESS_ROWS  = 300;
    localparam int              PRESS_SPLIT = 150;
    localparam bb3_pkg::t_pixel WHITE       = '{8'hFF, 8'hFF, 8'hFF};
    localparam t_blur_out       NO_RES      = '0;
    localparam t_blur_out       WHITE_RES   = '{8'hFF, 8'hFF, 8'hFF, 1'b0};
    localparam t_blur_out       WHITE_LAST  = '{8'hFF, 8'hFF, 8'hFF, 1'b1};

    // directed requests for a 3x3 image: a white frame with a pixel after the image,
    // then a frame of extremes with a drain inside the image, cut short
    localparam t_dir_row DIR_ROWS [24] = '{
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_NONE, NO_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_NONE, NO_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_NONE, NO_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_NONE, NO_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_DRAIN, '{8'h00, 8'h00, 8'h00}, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_DRAIN, '{8'h5A, 8'hA5, 8'h3C}, CHK_GIVEN, WHITE_RES},
        '{bb3_pkg::REQ_DRAIN, WHITE, CHK_GIVEN, WHITE_LAST},
        '{bb3_pkg::REQ_PIXEL, '{8'hFF, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_PIXEL, '{8'h00, 8'hFF, 8'h00}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_PIXEL, '{8'h00, 8'h00, 8'hFF}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_PIXEL, WHITE, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_DRAIN, WHITE, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_PIXEL, '{8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_PIXEL, '{8'h01, 8'h80, 8'hFE}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_PIXEL, '{8'hFF, 8'h00, 8'hFF}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_PIXEL, '{8'h7F, 8'h7F, 8'h80}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_DRAIN, '{8'h00, 8'h00, 8'h00}, CHK_MODEL, NO_RES},
        '{bb3_pkg::REQ_DRAIN, WHITE, CHK_MODEL, NO_RES}
    };

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [bb3_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [bb3_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [bb3_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         push       = 1'b0;
    logic                         full;
    logic                         i_req_type = bb3_pkg::REQ_PIXEL;
    logic [7:0]                   i_in_red   = '0;
    logic [7:0]                   i_in_green = '0;
    logic [7:0]                   i_in_blue  = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [7:0]                   o_out_red;
    logic [7:0]                   o_out_green;
    logic [7:0]                   o_out_blue;
    logic                         o_last_pixel;

    // blur predictor state
    logic [bb3_pkg::WIDTH_W-1:0]  cfg_width;
    logic [bb3_pkg::HEIGHT_W-1:0] cfg_height;
    bb3_pkg::t_pixel              upper_line [bb3_pkg::MAX_WIDTH];
    bb3_pkg::t_pixel              lower_line [bb3_pkg::MAX_WIDTH];
    bb3_pkg::t_pixel              blur_win [9];
    int unsigned                  col_pos;
    int unsigned                  row_pos;
    int unsigned                  emitted_pix;

    t_blur_out                    blurred_expect_q [$];
    int unsigned                  mismatch_cnt = 0;
    int unsigned                  items_sent   = 0;
    int unsigned                  results_seen = 0;
    bit                           no_idle      = 1'b0;

    box_blur_3x3_stream_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_in_red     (i_in_red),
        .i_in_green   (i_in_green),
        .i_in_blue    (i_in_blue),
        .empty        (empty),
        .pop          (pop),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_last_pixel (o_last_pixel)
    );

    always #6 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 40) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        mismatch_cnt++;
    endtask

    function automatic int unsigned eff_width(input logic [bb3_pkg::WIDTH_W-1:0] v);
        if (v == '0) return 1;
        if (v > bb3_pkg::MAX_WIDTH) return bb3_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic int unsigned eff_height(input logic [bb3_pkg::HEIGHT_W-1:0] v);
        if (v == '0) return 1;
        if (v > bb3_pkg::MAX_HEIGHT) return bb3_pkg::MAX_HEIGHT;
        return v;
    endfunction

    // one request through line stores and window; returns 1 when a blurred pixel is due
    function automatic bit blur_predict(input logic req, input bb3_pkg::t_pixel px_in,
                                        output t_blur_out res);
        bb3_pkg::t_pixel px;
        bb3_pkg::t_pixel up;
        bb3_pkg::t_pixel mid;
        int unsigned     w;
        int unsigned     h;
        int unsigned     n;
        int unsigned     crow;
        int unsigned     ccol;
        int unsigned     cnt;
        int unsigned     s_r;
        int unsigned     s_g;
        int unsigned     s_b;
        bit              row_ok [3];
        bit              col_ok [3];
        bit              got;
        w   = eff_width(cfg_width);
        h   = eff_height(cfg_height);
        px  = (req == bb3_pkg::REQ_PIXEL) ? px_in : '0;
        res = '0;
        got = 1'b0;
        up  = upper_line[col_pos];
        mid = lower_line[col_pos];
        upper_line[col_pos] = mid;
        lower_line[col_pos] = px;
        for (int r = 0; r < 3; r++) begin
            blur_win[r*3]   = blur_win[r*3+1];
            blur_win[r*3+1] = blur_win[r*3+2];
        end
        blur_win[2] = up;
        blur_win[5] = mid;
        blur_win[8] = px;
        n = row_pos * w + col_pos;
        if (n >= w + 1) begin
            crow = emitted_pix / w;
            ccol = emitted_pix % w;
            row_ok[0] = crow > 0;
            row_ok[1] = 1'b1;
            row_ok[2] = crow + 1 < h;
            col_ok[0] = ccol > 0;
            col_ok[1] = 1'b1;
            col_ok[2] = ccol + 1 < w;
            cnt = 0;
            s_r = 0;
            s_g = 0;
            s_b = 0;
            // sum the neighbors that lie inside the image
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (row_ok[r] && col_ok[c]) begin
                        s_r += blur_win[r*3+c].red;
                        s_g += blur_win[r*3+c].green;
                        s_b += blur_win[r*3+c].blue;
                        cnt++;
                    end
                end
            end
            // round half up
            res.red   = 8'((2 * s_r + cnt) / (2 * cnt));
            res.green = 8'((2 * s_g + cnt) / (2 * cnt));
            res.blue  = 8'((2 * s_b + cnt) / (2 * cnt));
            res.last  = (emitted_pix + 1 >= w * h);
            got = 1'b1;
            if (res.last) begin
                col_pos     = 0;
                row_pos     = 0;
                emitted_pix = 0;
                return 1'b1;
            end
            emitted_pix++;
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        return got;
    endfunction

    function automatic logic [7:0] rand_level();
        if ($urandom_range(4) == 0) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic bb3_pkg::t_pixel rand_pixel();
        bb3_pkg::t_pixel px;
        px.red   = rand_level();
        px.green = rand_level();
        px.blue  = rand_level();
        return px;
    endfunction

    // offer one request until accepted, then record what it should produce
    task automatic send_item(input logic req, input bb3_pkg::t_pixel px, input t_chk chk,
                             input t_blur_out want);
        t_blur_out res;
        bit        got;
        while (!no_idle && $urandom_range(99) < 7) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= req;
        i_in_red   <= px.red;
        i_in_green <= px.green;
        i_in_blue  <= px.blue;
        do @(posedge i_clk); while (full);
        got = blur_predict(req, px, res);
        case (chk)
            CHK_MODEL: begin
                if (got) blurred_expect_q.push_back(res);
            end
            CHK_GIVEN: blurred_expect_q.push_back(want);
            default: ;
        endcase
        items_sent++;
    endtask

    // pixels then drain requests, each type flipped with some chance
    task automatic send_frame(input int unsigned n_pix, input int unsigned n_drain,
                              input int unsigned noise_pct);
        logic req;
        for (int unsigned i = 0; i < n_pix + n_drain; i++) begin
            req = (i < n_pix) ? bb3_pkg::REQ_PIXEL : bb3_pkg::REQ_DRAIN;
            if ($urandom_range(99) < noise_pct) req = ~req;
            send_item(req, rand_pixel(), CHK_MODEL, NO_RES);
        end
    endtask

    // stop requesting until every blurred pixel is out, then let the pipe settle
    task automatic wait_drained(input int unsigned limit);
        int unsigned guard;
        guard = 0;
        push <= 1'b0;
        while (blurred_expect_q.size() != 0 && guard < limit) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYC) @(posedge i_clk);
    endtask

    // register write with random upper bits, then read back
    task automatic set_register(input logic idx, input logic [bb3_pkg::DATA_W-1:0] value);
        logic [bb3_pkg::DATA_W-1:0] wdata;
        logic [bb3_pkg::DATA_W-1:0] keep;
        wdata = $urandom;
        if (idx == bb3_pkg::REG_WIDTH) begin
            wdata[bb3_pkg::WIDTH_W-1:0] = value[bb3_pkg::WIDTH_W-1:0];
            keep = bb3_pkg::DATA_W'(value[bb3_pkg::WIDTH_W-1:0]);
        end else begin
            wdata[bb3_pkg::HEIGHT_W-1:0] = value[bb3_pkg::HEIGHT_W-1:0];
            keep = bb3_pkg::DATA_W'(value[bb3_pkg::HEIGHT_W-1:0]);
        end
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bb3_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == bb3_pkg::REG_WIDTH) cfg_width = keep[bb3_pkg::WIDTH_W-1:0];
        else                           cfg_height = keep[bb3_pkg::HEIGHT_W-1:0];
        // any write restarts the frame
        col_pos     = 0;
        row_pos     = 0;
        emitted_pix = 0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== keep) begin
            report_mismatch($sformatf("register %0d reads %h, wrote %h", idx, prdata, keep));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: check each accepted pixel, stall at random and once for a long stretch
    initial begin : result_side
        t_blur_out   got;
        t_blur_out   want;
        int unsigned hold_cnt;
        bit          held;
        hold_cnt = 0;
        held     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got = '{o_out_red, o_out_green, o_out_blue, o_last_pixel};
                results_seen++;
                if (blurred_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", got));
                end else begin
                    want = blurred_expect_q.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf(
                            "result %0d: rgb %h %h %h last %b, want %h %h %h last %b",
                            results_seen, got.red, got.green, got.blue, got.last,
                            want.red, want.green, want.blue, want.last));
                    end
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else if (!held && results_seen == HOLD_AT) begin
                held     = 1'b1;
                hold_cnt = HOLD_LEN;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(99) >= 7);
            end
        end
    end

    // request side and configuration
    initial begin : request_side
        int unsigned rand_end;
        int unsigned ew;
        int unsigned eh;
        int unsigned pick;
        logic [bb3_pkg::WIDTH_W-1:0]  wv;
        logic [bb3_pkg::HEIGHT_W-1:0] hv;
        cfg_width   = bb3_pkg::WIDTH_RESET;
        cfg_height  = bb3_pkg::HEIGHT_RESET;
        col_pos     = 0;
        row_pos     = 0;
        emitted_pix = 0;
        for (int i = 0; i < bb3_pkg::MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) blur_win[i] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed 3x3 table
        set_register(bb3_pkg::REG_WIDTH, 3);
        set_register(bb3_pkg::REG_HEIGHT, 3);
        foreach (DIR_ROWS[i]) begin
            send_item(DIR_ROWS[i].req, DIR_ROWS[i].px, DIR_ROWS[i].chk, DIR_ROWS[i].want);
        end
        wait_drained(20000);

        // width zero acts as one; no idling here, long result stall in the second half
        set_register(bb3_pkg::REG_WIDTH, 0);
        set_register(bb3_pkg::REG_HEIGHT, PRESS_ROWS);
        no_idle = 1'b1;
        send_frame(PRESS_SPLIT, 0, 0);
        // sender pause mid-frame until all results are out
        wait_drained(20000);
        send_frame(PRESS_ROWS - PRESS_SPLIT, 2, 0);
        no_idle = 1'b0;
        wait_drained(20000);

        // random geometries, mostly small, mostly well-formed frames
        rand_end = items_sent + RAND_ITEMS;
        while (items_sent < rand_end) begin
            pick = $urandom_range(99);
            if (pick < 5)       wv = 0;
            else if (pick < 70) wv = bb3_pkg::WIDTH_W'($urandom_range(1, 6));
            else if (pick < 95) wv = bb3_pkg::WIDTH_W'($urandom_range(7, 40));
            else                wv = bb3_pkg::WIDTH_W'($urandom_range(41, 100));
            hv = ($urandom_range(99) < 5) ? '0 : bb3_pkg::HEIGHT_W'($urandom_range(1, 5));
            case ($urandom_range(2))
                0: begin
                    set_register(bb3_pkg::REG_WIDTH, wv);
                    set_register(bb3_pkg::REG_HEIGHT, hv);
                end
                1: set_register(bb3_pkg::REG_WIDTH, wv);
                default: set_register(bb3_pkg::REG_HEIGHT, hv);
            endcase
            ew = eff_width(cfg_width);
            eh = eff_height(cfg_height);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(99) < 85) begin
                    send_frame(ew * eh, ew + 1, 3);
                end else begin
                    send_frame($urandom_range(0, ew * eh), $urandom_range(0, ew + 3), 20);
                end
            end
            wait_drained(20000);
        end

        if (blurred_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      blurred_expect_q.size()));
        end
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ box_blur_3x3_stream_core.f @@
hdl/bb3_pkg.sv
hdl/bb3_front.sv
hdl/bb3_queue.sv
hdl/bb3_back.sv
hdl/box_blur_3x3_stream_core.sv
tb/tb.sv
